// File: design/euler_quaternion_vector_rotate_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the vector rotate block
// Clocked implication checks shared by the rotate modules.
// ---------------------------------------------------------------------------
`ifndef EULER_QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH
`define EULER_QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH
// implication checked every clock outside reset
`define EQV_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define EQV_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: design/eqvr_pkg.sv
// ---------------------------------------------------------------------------
// eqvr_pkg
// Shared beat types and constants of the Euler vector rotate block.
// ---------------------------------------------------------------------------
package eqvr_pkg;
    localparam int CORDIC_MAX = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic               saturated;
    } out_beat_t;

    // arctangent table, 2^32 per turn
    function automatic logic signed [33:0] atan_turn(input int i);
        logic signed [33:0] t;
        case (i)
            0: t = 34'sh20000000;  1: t = 34'sh12E4051E;  2: t = 34'sh09FB385B;
            3: t = 34'sh051111D4;  4: t = 34'sh028B0D43;  5: t = 34'sh0145D7E1;
            6: t = 34'sh00A2F61E;  7: t = 34'sh00517C55;  8: t = 34'sh0028BE53;
            9: t = 34'sh00145F2F; 10: t = 34'sh000A2F98; 11: t = 34'sh000517CC;
            12: t = 34'sh00028BE6; 13: t = 34'sh000145F3; 14: t = 34'sh0000A2F9;
            15: t = 34'sh0000517D; 16: t = 34'sh000028BE; 17: t = 34'sh0000145F;
            18: t = 34'sh00000A30; 19: t = 34'sh00000518; 20: t = 34'sh0000028C;
            21: t = 34'sh00000146; 22: t = 34'sh000000A3; 23: t = 34'sh00000051;
            default: t = 34'sd0;
        endcase
        return t;
    endfunction

    // clamp to [-1, 1] in Q30
    function automatic logic signed [33:0] clamp_q30(input logic signed [35:0] v);
        logic signed [33:0] r;
        if (v > 36'sd1073741824)
            r = Q30_ONE;
        else if (v < -36'sd1073741824)
            r = -Q30_ONE;
        else
            r = v[33:0];
        return r;
    endfunction

    // Q30 product, round half up with floor shift
    function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic signed [67:0] p;
        p = a * b + 68'sd536870912;
        return p[63:30];
    endfunction
endpackage

// File: design/eqvr_cordic.sv
// ---------------------------------------------------------------------------
// eqvr_cordic
// Pipelined rotation-mode CORDIC giving cos and sin of a half angle, Q30.
// One iteration per register stage, plus a clamp stage.
// ---------------------------------------------------------------------------
module eqvr_cordic
    import eqvr_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16,
    parameter int STEPS = 16
)
(
    input  logic                          clk,
    input  logic signed [ANGLE_WIDTH-1:0] ang,
    output logic signed [33:0]            cos_q,
    output logic signed [33:0]            sin_q
);
    // x_reg[i] holds the output of micro-rotation i
    logic signed [33:0] x_reg [STEPS];
    logic signed [33:0] y_reg [STEPS];
    logic signed [33:0] z_reg [STEPS];
    logic signed [33:0] cos_reg, sin_reg;

    // one micro-rotation per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [33:0] x_in, y_in, z_in;

        // first stage takes the start vector and phase
        if (i == 0) begin : g_first
            assign x_in = CORDIC_GAIN;
            assign y_in = 34'sd0;
            assign z_in = 34'(ang) <<< (31 - ANGLE_WIDTH);
        end
        else begin : g_next
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (z_in >= 0)
            begin
                x_reg[i] <= x_in - (y_in >>> i);
                y_reg[i] <= y_in + (x_in >>> i);
                z_reg[i] <= z_in - atan_turn(i);
            end
            else
            begin
                x_reg[i] <= x_in + (y_in >>> i);
                y_reg[i] <= y_in - (x_in >>> i);
                z_reg[i] <= z_in + atan_turn(i);
            end
        end
    end

    // clamp stage
    always_ff @(posedge clk)
    begin
        cos_reg <= clamp_q30(36'(x_reg[STEPS-1]));
        sin_reg <= clamp_q30(36'(y_reg[STEPS-1]));
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;
endmodule

// File: design/eqvr_matrix.sv
// ---------------------------------------------------------------------------
// eqvr_matrix
// Composes yaw*pitch*roll and forms the clamped Q30 rotation matrix.
// Four register stages.
// ---------------------------------------------------------------------------
module eqvr_matrix
    import eqvr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [33:0] sr, cr, sp, cp, sy, cy,
    output logic signed [33:0] m [9]
);
    logic signed [33:0] cycp_reg, sysp_reg, cysp_reg, sycp_reg, sr_reg, cr_reg;
    logic signed [33:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [33:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [33:0] wx_reg, wy_reg, wz_reg;
    logic signed [33:0] m_reg [9];

    // pair products
    always_ff @(posedge clk)
    begin
        cycp_reg <= mul30(cy, cp);
        sysp_reg <= mul30(sy, sp);
        cysp_reg <= mul30(cy, sp);
        sycp_reg <= mul30(sy, cp);
        sr_reg   <= sr;
        cr_reg   <= cr;
    end

    // quaternion components
    always_ff @(posedge clk)
    begin
        w_reg <= mul30(cycp_reg, cr_reg) + mul30(sysp_reg, sr_reg);
        x_reg <= mul30(cycp_reg, sr_reg) - mul30(sysp_reg, cr_reg);
        y_reg <= mul30(cysp_reg, cr_reg) + mul30(sycp_reg, sr_reg);
        z_reg <= mul30(sycp_reg, cr_reg) - mul30(cysp_reg, sr_reg);
    end

    // component products
    always_ff @(posedge clk)
    begin
        xx_reg <= mul30(x_reg, x_reg);
        yy_reg <= mul30(y_reg, y_reg);
        zz_reg <= mul30(z_reg, z_reg);
        xy_reg <= mul30(x_reg, y_reg);
        xz_reg <= mul30(x_reg, z_reg);
        yz_reg <= mul30(y_reg, z_reg);
        wx_reg <= mul30(w_reg, x_reg);
        wy_reg <= mul30(w_reg, y_reg);
        wz_reg <= mul30(w_reg, z_reg);
    end

    // matrix entries, factor two, clamped
    always_ff @(posedge clk)
    begin
        m_reg[0] <= clamp_q30(36'(Q30_ONE) - 36'sd2 * (36'(yy_reg) + 36'(zz_reg)));
        m_reg[1] <= clamp_q30(36'sd2 * (36'(xy_reg) - 36'(wz_reg)));
        m_reg[2] <= clamp_q30(36'sd2 * (36'(xz_reg) + 36'(wy_reg)));
        m_reg[3] <= clamp_q30(36'sd2 * (36'(xy_reg) + 36'(wz_reg)));
        m_reg[4] <= clamp_q30(36'(Q30_ONE) - 36'sd2 * (36'(xx_reg) + 36'(zz_reg)));
        m_reg[5] <= clamp_q30(36'sd2 * (36'(yz_reg) - 36'(wx_reg)));
        m_reg[6] <= clamp_q30(36'sd2 * (36'(xz_reg) - 36'(wy_reg)));
        m_reg[7] <= clamp_q30(36'sd2 * (36'(yz_reg) + 36'(wx_reg)));
        m_reg[8] <= clamp_q30(36'(Q30_ONE) - 36'sd2 * (36'(xx_reg) + 36'(yy_reg)));
    end

    assign m = m_reg;

    // diagonal entries are checked once the pipeline holds real data
    `include "euler_quaternion_vector_rotate_top_defines.svh"
    `EQV_ASSERT_IMP(a_m00_range, !$isunknown(m_reg[0]), m_reg[0] <= Q30_ONE && m_reg[0] >= -Q30_ONE)
    `EQV_ASSERT_IMP(a_m11_range, !$isunknown(m_reg[4]), m_reg[4] <= Q30_ONE && m_reg[4] >= -Q30_ONE)
    `EQV_ASSERT_IMP(a_m22_range, !$isunknown(m_reg[8]), m_reg[8] <= Q30_ONE && m_reg[8] >= -Q30_ONE)
endmodule

// File: design/euler_quaternion_vector_rotate_top.sv
// ---------------------------------------------------------------------------
// euler_quaternion_vector_rotate_top
// Rotates a Q16.16 point by Euler angles composed as yaw*pitch*roll.
// ---------------------------------------------------------------------------
// Fully pipelined: busy is always low, so one beat may start every cycle.
// The pipeline holds one CORDIC stage per iteration and a
// clamp stage, four matrix stages, two point-product stages, one sum stage
// and one saturate stage. The result appears for one cycle with done high;
// the receiver cannot stall, so no result waits.
module euler_quaternion_vector_rotate_top
    import eqvr_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_beat_t  in_beat,
    output logic      busy,
    output logic      done,
    output out_beat_t out_beat
);
    localparam int STEPS = (TRIG_ITERATIONS < CORDIC_MAX) ? TRIG_ITERATIONS : CORDIC_MAX;
    localparam int CORD_LAT = STEPS + 1;
    localparam int LAT = CORD_LAT + 8;

    logic signed [33:0] sr, cr, sp, cp, sy, cy;
    logic signed [33:0] m [9];
    logic [LAT-1:0] vld_reg;
    logic signed [31:0] p_reg [CORD_LAT+4][3];
    logic signed [63:0] hi_reg [9];
    logic signed [63:0] lo_reg [9];
    logic signed [49:0] prod_reg [9];
    logic signed [51:0] acc_reg [3];
    out_beat_t out_reg;
    out_beat_t out_reg_next;

    assign busy = 1'b0;

    eqvr_cordic #(.ANGLE_WIDTH(16), .STEPS(STEPS)) u_roll
        (.clk(clk), .ang(in_beat.roll), .cos_q(cr), .sin_q(sr));
    eqvr_cordic #(.ANGLE_WIDTH(16), .STEPS(STEPS)) u_pitch
        (.clk(clk), .ang(in_beat.pitch), .cos_q(cp), .sin_q(sp));
    eqvr_cordic #(.ANGLE_WIDTH(16), .STEPS(STEPS)) u_yaw
        (.clk(clk), .ang(in_beat.yaw), .cos_q(cy), .sin_q(sy));

    eqvr_matrix u_matrix
        (.clk(clk), .rst_n(rst_n), .sr(sr), .cr(cr), .sp(sp), .cp(cp),
         .sy(sy), .cy(cy), .m(m));

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end

    // point delay line up to the matrix
    always_ff @(posedge clk)
    begin
        p_reg[0][0] <= in_beat.pos_x;
        p_reg[0][1] <= in_beat.pos_y;
        p_reg[0][2] <= in_beat.pos_z;
        for (int k = 1; k < CORD_LAT + 4; k++)
            p_reg[k] <= p_reg[k-1];
    end

    // split products: point high part and low 15 bits times entry
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                hi_reg[r*3+c] <= 64'(p_reg[CORD_LAT+3][c] >>> 15) * 64'(m[r*3+c]);
                lo_reg[r*3+c] <= 64'($signed({1'b0, p_reg[CORD_LAT+3][c][14:0]}))
                                 * 64'(m[r*3+c]) + 64'sd536870912;
            end
    end

    // combine into rounded Q16.16 products
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            prod_reg[k] <= 50'((hi_reg[k] + (lo_reg[k] >>> 15)) >>> 15);
    end

    // row sums
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
            acc_reg[r] <= 52'(prod_reg[r*3]) + 52'(prod_reg[r*3+1]) + 52'(prod_reg[r*3+2]);
    end

    // saturate
    always_comb
    begin
        logic signed [31:0] v [3];
        logic s;
        s = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            if (acc_reg[r] > 52'sd2147483647)
            begin
                v[r] = 32'sh7FFFFFFF;
                s = 1'b1;
            end
            else if (acc_reg[r] < -52'sd2147483648)
            begin
                v[r] = 32'sh80000000;
                s = 1'b1;
            end
            else
                v[r] = acc_reg[r][31:0];
        end
        out_reg_next = '{rot_x: v[0], rot_y: v[1], rot_z: v[2], saturated: s};
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_reg_next;
    end

    assign done = vld_reg[LAT-1];
    assign out_beat = out_reg;

    `include "euler_quaternion_vector_rotate_top_defines.svh"
    `EQV_ASSERT_IMP(a_never_busy, 1'b1, !busy)
    `EQV_ASSERT_NXT(a_start_tracked, start, vld_reg[0])
    `EQV_ASSERT_IMP(a_sat_flag, done && !out_beat.saturated,
        $past(acc_reg[0]) == 52'(out_beat.rot_x))
endmodule

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// Euler vector rotate testbench
// Drives points and Euler angles into the rotate pipeline and compares each
// rotated point against a bit-exact fixed-point predictor, with random gaps.
// ---------------------------------------------------------------------------
module testbench;
    import eqvr_pkg::*;

    localparam int STEPS = 16;
    localparam int LATENCY = STEPS + 9;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_beat_t  in_beat = '0;
    logic      busy;
    logic      done;
    out_beat_t out_beat;

    out_beat_t rotated_q[$];
    int        errors = 0;
    int        gap_pct = 0;

    euler_quaternion_vector_rotate_top #(.TRIG_ITERATIONS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .in_beat(in_beat),
        .busy(busy), .done(done), .out_beat(out_beat)
    );

    always #10 clk = ~clk;

    // floor shift right of a 64-bit signed value
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return floor_shr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    // Q16.16 coordinate times Q30 entry, split to stay inside 64 bits
    function automatic longint coord_mul(input longint c, input longint e);
        longint hi, lo;
        hi = floor_shr(c, 15);
        lo = c - hi * (64'sd1 <<< 15);
        return floor_shr(hi * e + floor_shr(lo * e + (64'sd1 <<< 29), 15), 15);
    endfunction

    // rotation-mode CORDIC on the half angle
    task automatic half_angle_trig(input logic signed [15:0] ang,
                                   output longint s, output longint c);
        longint z, x, y, dx, dy;
        z = longint'(ang) * (64'sd1 <<< 15);
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_turn(i));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_turn(i));
            end
        end
        c = clip(x, -(64'sd1 <<< 30), 64'sd1 <<< 30);
        s = clip(y, -(64'sd1 <<< 30), 64'sd1 <<< 30);
    endtask

    task automatic predict_rotation(input in_beat_t b, output out_beat_t r);
        longint sr, cr, sp, cp, sy, cy, w, x, y, z, acc, one;
        longint m[3][3];
        longint p[3];
        logic signed [31:0] o[3];
        logic sat;
        one = 64'sd1 <<< 30;
        p[0] = b.pos_x; p[1] = b.pos_y; p[2] = b.pos_z;
        half_angle_trig(b.roll, sr, cr);
        half_angle_trig(b.pitch, sp, cp);
        half_angle_trig(b.yaw, sy, cy);
        w = q30_mul(q30_mul(cy, cp), cr) + q30_mul(q30_mul(sy, sp), sr);
        x = q30_mul(q30_mul(cy, cp), sr) - q30_mul(q30_mul(sy, sp), cr);
        y = q30_mul(q30_mul(cy, sp), cr) + q30_mul(q30_mul(sy, cp), sr);
        z = q30_mul(q30_mul(sy, cp), cr) - q30_mul(q30_mul(cy, sp), sr);
        m[0][0] = one - 2 * (q30_mul(y, y) + q30_mul(z, z));
        m[0][1] = 2 * (q30_mul(x, y) - q30_mul(w, z));
        m[0][2] = 2 * (q30_mul(x, z) + q30_mul(w, y));
        m[1][0] = 2 * (q30_mul(x, y) + q30_mul(w, z));
        m[1][1] = one - 2 * (q30_mul(x, x) + q30_mul(z, z));
        m[1][2] = 2 * (q30_mul(y, z) - q30_mul(w, x));
        m[2][0] = 2 * (q30_mul(x, z) - q30_mul(w, y));
        m[2][1] = 2 * (q30_mul(y, z) + q30_mul(w, x));
        m[2][2] = one - 2 * (q30_mul(x, x) + q30_mul(y, y));
        sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += coord_mul(p[j], clip(m[i][j], -one, one));
            if (acc < -(64'sd1 <<< 31) || acc > (64'sd1 <<< 31) - 1)
                sat = 1'b1;
            o[i] = 32'(clip(acc, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
        end
        r.rot_x = o[0]; r.rot_y = o[1]; r.rot_z = o[2]; r.saturated = sat;
    endtask

    // send one beat, with a random idle gap before it
    task automatic send_point(input in_beat_t b);
        out_beat_t r;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        in_beat <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_rotation(b, r);
        rotated_q.push_back(r);
    endtask

    // drop start so the stream ends before the next sender starts
    task automatic stop_sending();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic in_beat_t random_point(input bit small_coords);
        in_beat_t b;
        b.pos_x = $urandom;
        b.pos_y = $urandom;
        b.pos_z = $urandom;
        b.roll  = 16'($urandom);
        b.pitch = 16'($urandom);
        b.yaw   = 16'($urandom);
        if (small_coords)
        begin
            b.pos_x = $signed(b.pos_x) >>> $urandom_range(16, 0);
            b.pos_y = $signed(b.pos_y) >>> $urandom_range(16, 0);
            b.pos_z = $signed(b.pos_z) >>> $urandom_range(16, 0);
        end
        return b;
    endfunction

    // compare each result with the oldest prediction
    always @(posedge clk)
    begin
        out_beat_t e;
        if (rst_n && done)
        begin
            if (rotated_q.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
            end
            else
            begin
                e = rotated_q.pop_front();
                if (out_beat.rot_x !== e.rot_x)
                begin
                    $error("rot_x expected %0d actual %0d", e.rot_x, out_beat.rot_x);
                    errors++;
                end
                if (out_beat.rot_y !== e.rot_y)
                begin
                    $error("rot_y expected %0d actual %0d", e.rot_y, out_beat.rot_y);
                    errors++;
                end
                if (out_beat.rot_z !== e.rot_z)
                begin
                    $error("rot_z expected %0d actual %0d", e.rot_z, out_beat.rot_z);
                    errors++;
                end
                if (out_beat.saturated !== e.saturated)
                begin
                    $error("saturated expected %0d actual %0d", e.saturated,
                           out_beat.saturated);
                    errors++;
                end
            end
        end
    end

    // extremes of coordinates and angles, including -pi and overflow
    task automatic test_directed();
        in_beat_t b;
        logic signed [15:0] angs[6];
        logic signed [31:0] crd[4];
        angs = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sh4000, -16'sh4000, 16'sd1};
        crd = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, 32'sd0};
        for (int i = 0; i < 6; i++)
        begin
            b.pos_x = crd[i % 4]; b.pos_y = crd[(i + 1) % 4]; b.pos_z = crd[(i + 2) % 4];
            b.roll = angs[i]; b.pitch = angs[(i + 2) % 6]; b.yaw = angs[(i + 4) % 6];
            send_point(b);
        end
        // large point under 45 degree turns overflows
        b = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh2000, 16'sh2000, 16'sh2000};
        send_point(b);
        b = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sh8000, 16'sh8000, 16'sh8000};
        send_point(b);
        b = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 16'sh6000, -16'sh2000, 16'sh8000};
        send_point(b);
        b = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_point(b);
        b = '0;
        send_point(b);
        for (int i = 0; i < 6; i++)
        begin
            b = '{32'sh00010000, 32'sh00020000, -32'sh00030000, 16'sd0, 16'sd0, 16'sd0};
            if (i < 3) b.roll = (i == 0) ? 16'sh8000 : 16'sh7FFF;
            else b.yaw = (i == 3) ? 16'sh8000 : -16'sh7FFF;
            send_point(b);
        end
        stop_sending();
    endtask

    task automatic test_random(input int pct, input int count);
        gap_pct = pct;
        for (int i = 0; i < count; i++)
            send_point(random_point($urandom_range(3, 0) != 0));
        stop_sending();
    endtask

    initial
    begin
        int wait_cycles;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(32, 130);
        test_random(57, 130);
        test_random(0, 140);
        wait_cycles = 0;
        while (rotated_q.size() != 0 && wait_cycles < 10 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY) @(posedge clk);
        if (errors == 0 && rotated_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+design
design/eqvr_pkg.sv
design/eqvr_cordic.sv
design/eqvr_matrix.sv
design/euler_quaternion_vector_rotate_top.sv
sim/testbench.sv
